FILE: hw/rtl/bpc_pkg.sv
// bpc_pkg: shared types and constants of the button press classifier
// no dependencies; compiled first

package bpc_pkg;

    localparam int unsigned NUM_BUTTONS    = 4;
    localparam int unsigned TIME_WIDTH_DEF = 32;
    localparam int unsigned CFG_W          = 16;
    localparam int unsigned CFG_IDX_W      = 8;
    localparam int unsigned BTN_IDX_W      = $clog2(NUM_BUTTONS);

    // button indexes, also the bit order of the acknowledge mask
    localparam logic [BTN_IDX_W-1:0] BTN_UP    = 2'd0;
    localparam logic [BTN_IDX_W-1:0] BTN_DOWN  = 2'd1;
    localparam logic [BTN_IDX_W-1:0] BTN_POWER = 2'd2;
    localparam logic [BTN_IDX_W-1:0] BTN_MENU  = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BACKOFF    = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UP_THRESH  = 8'd3;

    // register reset values
    localparam logic [CFG_W-1:0] RST_LONG_PRESS = 16'd1000;
    localparam logic [CFG_W-1:0] RST_DEBOUNCE   = 16'd50;
    localparam logic [CFG_W-1:0] RST_BACKOFF    = 16'd0;
    localparam logic [CFG_W-1:0] RST_UP_THRESH  = 16'd1000;

    typedef enum logic [1:0] {
        CLS_RELEASED = 2'd0,
        CLS_DOWN     = 2'd1,
        CLS_PRESSED  = 2'd2,
        CLS_LONG     = 2'd3
    } t_class;

    // per-tick control from the top level to one button
    typedef struct packed {
        logic step;   // tick accepted and outside the backoff window
        logic ack;    // tick accepted with this button's acknowledge bit
        logic held;   // button level for this tick
    } t_btn_ctrl;

    typedef struct packed {
        logic [CFG_W-1:0] long_ticks;
        logic [CFG_W-1:0] debounce_ticks;
    } t_btn_cfg;

endpackage

FILE: hw/rtl/bpc_ifs.sv
// bpc_ifs: valid/ready channel interfaces of the button press classifier
// depends on bpc_pkg

interface bpc_in_if;
    import bpc_pkg::*;
    logic              valid;
    logic              ready;
    logic              power_pin;
    logic              down_pin;
    logic              menu_pin;
    logic [CFG_W-1:0]  up_sample;
    logic [NUM_BUTTONS-1:0] ack_mask;
    logic              backoff_begin;

    modport source (output valid, power_pin, down_pin, menu_pin, up_sample, ack_mask,
                    backoff_begin, input ready);
    modport sink   (input valid, power_pin, down_pin, menu_pin, up_sample, ack_mask,
                    backoff_begin, output ready);
endinterface

interface bpc_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] up_state;
    logic [1:0] down_state;
    logic [1:0] power_state;
    logic [1:0] menu_state;

    modport source (output valid, up_state, down_state, power_state, menu_state,
                    input ready);
    modport sink   (input valid, up_state, down_state, power_state, menu_state,
                    output ready);
endinterface

interface bpc_cfg_if;
    import bpc_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/bpc_button.sv
// bpc_button: state machine of one button (released, down, pressed, long pressed)
// depends on bpc_pkg

module bpc_button #(
    parameter int unsigned TIME_WIDTH = bpc_pkg::TIME_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  bpc_pkg::t_btn_ctrl    i_ctrl,
    input  bpc_pkg::t_btn_cfg     i_cfg,
    input  logic [TIME_WIDTH-1:0] i_now,
    output bpc_pkg::t_class       o_class
);
    import bpc_pkg::*;

    t_class                r_class, n_class, w_acked;
    logic [TIME_WIDTH-1:0] r_start, n_start;
    logic [TIME_WIDTH-1:0] w_elapsed;
    logic                  w_long, w_debounced;

    // wrap-safe hold time
    assign w_elapsed   = i_now - r_start;
    assign w_long      = w_elapsed > TIME_WIDTH'(i_cfg.long_ticks);
    assign w_debounced = w_elapsed > TIME_WIDTH'(i_cfg.debounce_ticks);

    // acknowledge comes first, also inside the backoff window
    assign w_acked = (i_ctrl.ack && r_class == CLS_PRESSED) ? CLS_RELEASED : r_class;

    always_comb begin
        n_class = w_acked;
        n_start = r_start;
        if (i_ctrl.step) begin
            if (i_ctrl.held) begin
                if (w_acked == CLS_RELEASED) begin
                    n_class = CLS_DOWN;
                    n_start = i_now;
                end else if (w_acked == CLS_DOWN && w_long) begin
                    n_class = CLS_LONG;
                end
            end else begin
                if (w_acked == CLS_DOWN && w_debounced) begin
                    n_class = CLS_PRESSED;
                    n_start = '0;
                end else if (w_acked != CLS_PRESSED) begin
                    n_class = CLS_RELEASED;
                    n_start = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_class <= CLS_RELEASED;
            r_start <= '0;
        end else begin
            r_class <= n_class;
            r_start <= n_start;
        end
    end

    assign o_class = r_class;

endmodule

FILE: hw/rtl/button_press_classifier.sv
// button_press_classifier: top level, four button classifiers with backoff window
// depends on bpc_pkg, bpc_ifs (bpc_in_if, bpc_out_if, bpc_cfg_if) and bpc_button
//
//  port    dir   carries per transfer
//  ------  ----  -------------------------------------------------------------
//  i_in    in    one tick: three pin levels, up ADC sample, ack mask, backoff start
//  o_out   out   class of up, down, power and menu after that tick
//  i_cfg   in    register index and 16-bit write data, always ready
//
//  each tick is classified in the cycle it is accepted; its result is valid the next cycle
//  a tick is accepted every cycle while the result register is empty or being taken
//  the button state registers also form the result register
//  reset (synchronous, active low) releases all buttons, zeroes the tick counter and
//  backoff origin, loads the register defaults and empties the result register
//  a stalled result holds the input off; nothing is dropped

module button_press_classifier #(
    parameter int unsigned TIME_WIDTH = bpc_pkg::TIME_WIDTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bpc_in_if.sink    i_in,
    bpc_out_if.source o_out,
    bpc_cfg_if.sink   i_cfg
);
    import bpc_pkg::*;

    // configuration registers
    logic [CFG_W-1:0] r_long_ticks;
    logic [CFG_W-1:0] r_debounce_ticks;
    logic [CFG_W-1:0] r_backoff_ticks;
    logic [CFG_W-1:0] r_up_thresh;

    // time base and backoff window
    logic [TIME_WIDTH-1:0] r_tick, r_origin, n_origin;
    logic [TIME_WIDTH-1:0] w_since_origin;
    logic                  w_skip;

    // handshake
    logic r_out_valid;
    logic w_in_xfer;

    logic [NUM_BUTTONS-1:0] w_held;
    t_btn_ctrl              w_ctrl  [NUM_BUTTONS];
    t_class                 w_class [NUM_BUTTONS];
    t_btn_cfg               w_btn_cfg;

    // register writes, always accepted
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_ticks     <= RST_LONG_PRESS;
            r_debounce_ticks <= RST_DEBOUNCE;
            r_backoff_ticks  <= RST_BACKOFF;
            r_up_thresh      <= RST_UP_THRESH;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_LONG_PRESS: r_long_ticks     <= i_cfg.data;
                CFG_DEBOUNCE:   r_debounce_ticks <= i_cfg.data;
                CFG_BACKOFF:    r_backoff_ticks  <= i_cfg.data;
                CFG_UP_THRESH:  r_up_thresh      <= i_cfg.data;
                default: ;  // unknown index, write dropped
            endcase
        end
    end

    // take a new tick whenever the result slot is free or drains this cycle
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_in_xfer  = i_in.valid && i_in.ready;

    // a backoff start on this tick moves the origin to now, so this tick is
    // skipped unless the window length is zero
    assign n_origin       = i_in.backoff_begin ? r_tick : r_origin;
    assign w_since_origin = r_tick - n_origin;
    assign w_skip         = w_since_origin < TIME_WIDTH'(r_backoff_ticks);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick      <= '0;
            r_origin    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_xfer) begin
                r_tick   <= r_tick + TIME_WIDTH'(1);
                r_origin <= n_origin;
            end
            if (w_in_xfer) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // button levels: up from its ADC sample, the rest active low
    assign w_held[BTN_UP]    = i_in.up_sample <= r_up_thresh;
    assign w_held[BTN_DOWN]  = !i_in.down_pin;
    assign w_held[BTN_POWER] = !i_in.power_pin;
    assign w_held[BTN_MENU]  = !i_in.menu_pin;

    assign w_btn_cfg.long_ticks     = r_long_ticks;
    assign w_btn_cfg.debounce_ticks = r_debounce_ticks;

    for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_btn
        assign w_ctrl[g].step = w_in_xfer && !w_skip;
        assign w_ctrl[g].ack  = w_in_xfer && i_in.ack_mask[g];
        assign w_ctrl[g].held = w_held[g];

        bpc_button #(
            .TIME_WIDTH (TIME_WIDTH)
        ) u_button (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (w_ctrl[g]),
            .i_cfg   (w_btn_cfg),
            .i_now   (r_tick),
            .o_class (w_class[g])
        );
    end

    // the button state registers only change on an accepted tick, so they
    // double as the result register
    assign o_out.valid       = r_out_valid;
    assign o_out.up_state    = w_class[BTN_UP];
    assign o_out.down_state  = w_class[BTN_DOWN];
    assign o_out.power_state = w_class[BTN_POWER];
    assign o_out.menu_state  = w_class[BTN_MENU];

    // every accepted tick leaves a result behind
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> r_out_valid)
        else $error("accepted tick left no result");

    // a pending result that is not taken blocks the next tick
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |-> !i_in.ready)
        else $error("tick accepted over a pending result");

    // tick counter moves exactly once per accepted tick
    a_tick_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> r_tick == $past(r_tick) + TIME_WIDTH'(1))
        else $error("tick counter out of step");

    // a skipped tick without acknowledge leaves every button as it was
    a_skip_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_xfer && w_skip && i_in.ack_mask == '0) |=>
            ($stable(w_class[BTN_UP]) && $stable(w_class[BTN_DOWN]) &&
             $stable(w_class[BTN_POWER]) && $stable(w_class[BTN_MENU])))
        else $error("button changed inside backoff window");

endmodule
